@@ rtl/core/stb_pkg.sv @@
// Package: shared types and constants for the soft timer bank.
`timescale 1ns / 1ps
package stb_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_EVT  = 16;
  localparam int EVT_W    = $clog2(MAX_EVT + 1);

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_ARM    = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOSLT = 2'd2;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [15:0] tick_period;
    logic        use_callback;
    logic [31:0] interval_value;
    logic        periodic;
    logic        run;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic        fired_callback;
    logic        timeout_flag;
    logic [31:0] time_now;
    logic        last;
  } out_item_t;

  // per-slot record kept in the slot memory
  typedef struct packed {
    logic        cb_kind;
    logic        running;
    logic        periodic;
    logic        flag;
    logic [31:0] start;
    logic [31:0] interval;
  } slot_rec_t;

endpackage

@@ rtl/core/soft_timer_bank.sv @@
// Top level: soft timer bank with a memory-held slot table and a slot scanner.
`timescale 1ns / 1ps
// A bank of software timers sharing one 32-bit time count. Each input
// transaction carries one op (tick, create, delete, arm, read). Slot records
// (kind, run, periodic, flag, start, interval) live in a one-port-read,
// one-port-write synchronous memory; only the in-use bits are flip-flops,
// cleared at reset. Create, delete, arm and read pass a read state and an
// op state, then wait on the output handshake. Create finds the lowest free
// slot from the in-use bits in one step. A tick walks the memory twice
// (callback timers, then flag timers), with a slot read state and an
// evaluate state per slot; the scan holds while a buffered event waits on
// the output, and a tick ends with the handshake of its final event.
// Events are capped at 16 per tick; later expiries are still applied. Ops
// 5 to 7 are dropped without a result. No clearing pass.
module soft_timer_bank (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output stb_pkg::out_item_t out_data
);

  localparam int SW = stb_pkg::SLOT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_OP    = 6'b000100,
    S_SCAN  = 6'b001000,
    S_EVAL  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state;
  stb_pkg::in_item_t req;
  logic [31:0] time_count;
  logic [stb_pkg::SLOTS-1:0] used;

  // slot memory
  stb_pkg::slot_rec_t mem [stb_pkg::SLOTS];
  stb_pkg::slot_rec_t rd_data;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  stb_pkg::slot_rec_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // scanner
  logic [SW:0]   idx;        // slot being read; also counts to SLOTS
  logic [SW-1:0] eidx;       // slot whose data is in rd_data
  logic          pass_cb;    // 1: callback pass
  logic [stb_pkg::EVT_W-1:0] evt_cnt;
  logic          pend;       // an event sits in evt_buf
  stb_pkg::out_item_t evt_buf;

  // lowest free slot
  logic          free_found;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = stb_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  logic          slot_ok;
  logic [SW-1:0] s_idx;
  assign slot_ok = ({28'd0, req.slot} < 32'(stb_pkg::SLOTS)) && used[SW'(req.slot)];
  assign s_idx   = SW'(req.slot);

  logic expired;
  logic [31:0] elapsed;
  assign elapsed = time_count - rd_data.start;
  assign expired = used[eidx] && (rd_data.cb_kind == pass_cb) && rd_data.running
                   && (elapsed >= rd_data.interval);

  // event decision for the slot under evaluation
  logic emit;
  logic flag_after;
  always_comb begin
    emit       = 1'b0;
    flag_after = 1'b0;
    if (expired) begin
      if (pass_cb) begin
        emit       = 1'b1;
        flag_after = rd_data.periodic;
      end else begin
        emit       = !rd_data.flag;
        flag_after = 1'b1;
      end
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  // keep re-reading the evaluated slot while the scan holds
  always_comb begin
    rd_addr = s_idx;
    if (state == S_SCAN) begin
      rd_addr = idx[SW-1:0];
    end else if (state == S_EVAL) begin
      rd_addr = eidx;
    end
  end

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      time_count <= '0;
      used       <= '0;
      out_valid  <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data;
            if (in_data.op == stb_pkg::OP_TICK) begin
              time_count <= time_count + {16'd0, in_data.tick_period};
              idx     <= '0;
              pass_cb <= 1'b1;
              evt_cnt <= '0;
              pend    <= 1'b0;
              state   <= S_SCAN;
            end else if (in_data.op <= stb_pkg::OP_READ) begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_OP;  // rd_data valid next cycle
        end
        S_OP: begin
          out_data.kind           <= stb_pkg::KIND_REPLY;
          out_data.fired_callback <= 1'b0;
          out_data.timeout_flag   <= 1'b0;
          out_data.time_now       <= time_count;
          out_data.last           <= 1'b1;
          out_data.slot_out       <= req.slot;
          out_data.status         <= slot_ok ? stb_pkg::ST_OK : stb_pkg::ST_NOSLT;
          out_valid <= 1'b1;
          state     <= S_IDLE;
          case (req.op)
            stb_pkg::OP_CREATE: begin
              if (free_found) begin
                used[free_idx] <= 1'b1;
                wr_en   <= 1'b1;
                wr_addr <= free_idx;
                wr_data <= '{cb_kind: req.use_callback, running: 1'b0, periodic: 1'b0,
                             flag: 1'b0, start: time_count, interval: 32'd0};
                out_data.status   <= stb_pkg::ST_OK;
                out_data.slot_out <= 4'(free_idx);
              end else begin
                out_data.status   <= stb_pkg::ST_FULL;
                out_data.slot_out <= 4'd0;
              end
            end
            stb_pkg::OP_DELETE: begin
              if (slot_ok) begin
                used[s_idx] <= 1'b0;
              end
            end
            stb_pkg::OP_ARM: begin
              if (slot_ok) begin
                wr_en   <= 1'b1;
                wr_addr <= s_idx;
                wr_data <= '{cb_kind: rd_data.cb_kind, running: req.run,
                             periodic: req.periodic, flag: 1'b0, start: time_count,
                             interval: req.interval_value};
              end
            end
            default: begin
              out_data.timeout_flag <= slot_ok && rd_data.flag;
            end
          endcase
        end
        S_SCAN: begin
          // issue read of slot idx
          eidx  <= idx[SW-1:0];
          idx   <= idx + 1'b1;
          state <= S_EVAL;
        end
        S_EVAL: begin
          // hold while the buffered event cannot move to the output
          if (pend && out_valid && !out_ready) begin
            state <= S_EVAL;
          end else begin
            if (expired) begin
              if (pass_cb) begin
                if (rd_data.periodic) begin
                  wr_en   <= 1'b1;
                  wr_addr <= eidx;
                  wr_data <= '{cb_kind: rd_data.cb_kind, running: rd_data.running,
                               periodic: 1'b1, flag: 1'b1, start: time_count,
                               interval: rd_data.interval};
                end else begin
                  used[eidx] <= 1'b0;
                end
              end else begin
                wr_en   <= 1'b1;
                wr_addr <= eidx;
                wr_data <= '{cb_kind: rd_data.cb_kind, running: rd_data.running,
                             periodic: rd_data.periodic, flag: 1'b1,
                             start: rd_data.start, interval: rd_data.interval};
              end
            end
            if (emit && (evt_cnt < stb_pkg::EVT_W'(stb_pkg::MAX_EVT))) begin
              evt_buf.kind           <= stb_pkg::KIND_EVENT;
              evt_buf.status         <= stb_pkg::ST_OK;
              evt_buf.slot_out       <= 4'(eidx);
              evt_buf.fired_callback <= pass_cb;
              evt_buf.timeout_flag   <= flag_after;
              evt_buf.time_now       <= time_count;
              evt_buf.last           <= 1'b0;
              // held until the scan ends or the next event shows up
              pend    <= 1'b1;
              evt_cnt <= evt_cnt + 1'b1;
              if (pend) begin
                out_data  <= evt_buf;
                out_valid <= 1'b1;
              end
            end
            if (idx == (SW+1)'(stb_pkg::SLOTS)) begin
              if (pass_cb) begin
                pass_cb <= 1'b0;
                idx     <= '0;
                state   <= S_SCAN;
              end else begin
                state <= S_FIN;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_FIN: begin
          // release the buffered final event with last set
          if (!(out_valid && !out_ready)) begin
            if (pend) begin
              out_data  <= '{kind: evt_buf.kind, status: evt_buf.status,
                             slot_out: evt_buf.slot_out,
                             fired_callback: evt_buf.fired_callback,
                             timeout_flag: evt_buf.timeout_flag,
                             time_now: evt_buf.time_now, last: 1'b1};
              out_valid <= 1'b1;
            end
            pend  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
